FILE: rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants of the LRU key/value cache: field widths,
// operation codes, register index and the entry word that moves along the
// chain of cells.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   // default number of cells
   localparam int ENTRIES_DEFAULT = 8;

   // payload widths
   localparam int KEY_W   = 32;
   localparam int VALUE_W = 32;

   // capacity register
   localparam int CAP_W           = 4;
   localparam int CAP_RESET_VALUE = 8;

   // configuration port
   localparam int DATA_W = 32;
   localparam int ADDR_W = 3;

   // register index, taken from the word address bit
   localparam logic REG_CAPACITY = 1'b0;

   // operation codes
   typedef enum logic {
      KIND_GET = 1'b0,
      KIND_PUT = 1'b1
   } kind_type;

   // one entry as held by a cell and handed to its neighbour
   typedef struct packed {
      logic               valid;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

FILE: rtl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell
// One cell of the recency chain. Its place in the chain is its rank: cell 0
// holds the most recent entry. On an update every cell at or below the
// boundary takes the entry of the cell before it, cell 0 takes the new one.
// ----------------------------------------------------------------------------
module lkvc_cell #(
   parameter int IDX_W    = $clog2(lkvc_pkg::ENTRIES_DEFAULT),
   parameter int CELL_IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       update,
   input  logic [IDX_W-1:0]           boundary,
   input  lkvc_pkg::entry_type        prev,
   input  logic [lkvc_pkg::KEY_W-1:0] query_key,
   output lkvc_pkg::entry_type        entry,
   output logic                       hit
);

   logic                           valid_ff, valid_in;
   logic [lkvc_pkg::KEY_W-1:0]     key_ff, key_in;
   logic [lkvc_pkg::VALUE_W-1:0]   value_ff, value_in;
   logic                           shift;

   // this cell moves when the boundary lies at or beyond it
   assign shift = update && (IDX_W'(CELL_IDX) <= boundary);

   // next contents
   always_comb begin
      valid_in = shift ? prev.valid : valid_ff;
      key_in   = shift ? prev.key   : key_ff;
      value_in = shift ? prev.value : value_ff;
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // key and value words
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   // key compare
   assign hit = valid_ff && (key_ff == query_key);

   assign entry.valid = valid_ff;
   assign entry.key   = key_ff;
   assign entry.value = value_ff;

endmodule

FILE: rtl/lkvc_csr.sv
// ----------------------------------------------------------------------------
// lkvc_csr
// Register port holding the capacity. Written values of zero are taken as
// one and values above the cell count saturate.
// ----------------------------------------------------------------------------
module lkvc_csr #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lkvc_pkg::ADDR_W-1:0] paddr,
   input  logic [lkvc_pkg::DATA_W-1:0] pwdata,
   output logic [lkvc_pkg::DATA_W-1:0] prdata,
   output logic                        pready,
   output logic [lkvc_pkg::CAP_W-1:0]  capacity
);

   localparam int CAP_LIMIT = (1 << lkvc_pkg::CAP_W) - 1;
   localparam logic [lkvc_pkg::CAP_W-1:0] CAP_MAX =
      lkvc_pkg::CAP_W'((ENTRIES > CAP_LIMIT) ? CAP_LIMIT : ENTRIES);
   localparam logic [lkvc_pkg::CAP_W-1:0] CAP_RESET =
      lkvc_pkg::CAP_W'((lkvc_pkg::CAP_RESET_VALUE > ENTRIES) ?
                       ENTRIES : lkvc_pkg::CAP_RESET_VALUE);

   logic [lkvc_pkg::CAP_W-1:0] capacity_ff, capacity_in;
   logic [lkvc_pkg::CAP_W-1:0] wr_data;
   logic                       sel_capacity;
   logic                       wr_en;

   assign pready       = 1'b1;
   assign sel_capacity = (paddr[2] == lkvc_pkg::REG_CAPACITY);
   assign wr_en        = psel && penable && pwrite && pready && sel_capacity;

   // clamp of the written word
   always_comb begin
      wr_data = pwdata[lkvc_pkg::CAP_W-1:0];
      if (wr_data == '0) begin
         wr_data = lkvc_pkg::CAP_W'(1);
      end else if (wr_data > CAP_MAX) begin
         wr_data = CAP_MAX;
      end
      capacity_in = wr_en ? wr_data : capacity_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // read back
   assign prdata   = sel_capacity ? lkvc_pkg::DATA_W'(capacity_ff) : '0;
   assign capacity = capacity_ff;

endmodule

FILE: rtl/lru_key_value_cache.sv
// Result: rsp_strobe and the result word are registered and appear in the cycle after start is taken.
// Throughput: one operation per cycle; compare, boundary select and chain
// shift of all cells complete in the accepting cycle. busy stays low.
// Reset (synchronous): all cells empty, occupancy zero, capacity eight or
// the cell count if smaller. The receiver cannot stall the result word.
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value store with least-recently-used replacement,
// built as a chain of cells ordered by recency.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
   parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_kind,
   input  logic [lkvc_pkg::KEY_W-1:0]    req_key,
   input  logic [lkvc_pkg::VALUE_W-1:0]  req_write_value,
   output logic                          rsp_strobe,
   output logic                          rsp_found,
   output logic [lkvc_pkg::VALUE_W-1:0]  rsp_read_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lkvc_pkg::ADDR_W-1:0]   paddr,
   input  logic [lkvc_pkg::DATA_W-1:0]   pwdata,
   output logic [lkvc_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

   logic [lkvc_pkg::CAP_W-1:0]    capacity;
   logic                          accept;
   logic                          is_put;
   logic [ENTRIES-1:0]            hit;
   logic [ENTRIES-1:0]            valid_vec;
   logic                          hit_any;
   logic [IDX_W-1:0]              hit_idx;
   logic [lkvc_pkg::VALUE_W-1:0]  hit_value;
   logic                          full;
   logic [OCC_W-1:0]              occ_dec;
   logic [IDX_W-1:0]              boundary;
   logic                          update;
   lkvc_pkg::entry_type           head;
   lkvc_pkg::entry_type           cell_entry [ENTRIES];

   logic [OCC_W-1:0]              occupancy_ff, occupancy_in;
   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [lkvc_pkg::VALUE_W-1:0]  rsp_read_value_ff, rsp_read_value_in;

   // register port
   lkvc_csr #(
      .ENTRIES (ENTRIES)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign is_put = (req_kind == lkvc_pkg::KIND_PUT);

   // hit position and hit value across the chain
   always_comb begin
      hit_idx   = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit[i]) begin
            hit_idx   = hit_idx | IDX_W'(i);
            hit_value = hit_value | cell_entry[i].value;
         end
      end
      hit_any = |hit;
   end

   // shift boundary: hit cell, least recent cell on eviction, or first free
   always_comb begin
      full     = CMP_W'(occupancy_ff) >= CMP_W'(capacity);
      occ_dec  = occupancy_ff - OCC_W'(1);
      if (hit_any) begin
         boundary = hit_idx;
      end else if (full) begin
         boundary = occ_dec[IDX_W-1:0];
      end else begin
         boundary = occupancy_ff[IDX_W-1:0];
      end
      update = accept && (hit_any || is_put);
   end

   // new most recent entry
   always_comb begin
      head.valid = 1'b1;
      head.key   = req_key;
      head.value = is_put ? req_write_value : hit_value;
   end

   // chain of cells
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkvc_pkg::entry_type prev;
      if (g == 0) begin : g_head
         assign prev = head;
      end else begin : g_link
         assign prev = cell_entry[g-1];
      end
      lkvc_cell #(
         .IDX_W    (IDX_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .update    (update),
         .boundary  (boundary),
         .prev      (prev),
         .query_key (req_key),
         .entry     (cell_entry[g]),
         .hit       (hit[g])
      );
      assign valid_vec[g] = cell_entry[g].valid;
   end

   // occupancy grows only on an insert without eviction
   always_comb begin
      occupancy_in = occupancy_ff;
      if (accept && is_put && !hit_any && !full) begin
         occupancy_in = occupancy_ff + OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   // result word
   always_comb begin
      rsp_strobe_in     = accept;
      rsp_found_in      = hit_any;
      rsp_read_value_in = (!is_put && hit_any) ? hit_value : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff      <= rsp_found_in;
      rsp_read_value_ff <= rsp_read_value_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_read_value = rsp_read_value_ff;

`ifndef SYNTHESIS
   // a key sits in at most one cell
   assert property (@(posedge clock) disable iff (reset) $onehot0(hit))
      else $error("key present in more than one cell");

   // valid cells match the occupancy count
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(occupancy_ff))
      else $error("valid cells disagree with occupancy");

   // occupancy never exceeds the cell count
   assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= OCC_W'(ENTRIES))
      else $error("occupancy above cell count");

   // an accepted write leaves its key as the most recent entry
   assert property (@(posedge clock) disable iff (reset)
      accept && is_put |=> cell_entry[0].valid && cell_entry[0].key == $past(req_key))
      else $error("written key not at head of chain");

   // misses and writes return a zero value
   assert property (@(posedge clock) disable iff (reset)
      accept && (is_put || !hit_any) |=> rsp_read_value == '0)
      else $error("non-zero value on miss or write");
`endif

endmodule

FILE: tb/lkvc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_checker
// Watches the request, reply and register ports of the LRU key/value cache,
// keeps its own copy of the cache contents and recency order, predicts each
// reply and compares it with the word that comes back.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
#(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic               req_kind,
   input  logic [KEY_W-1:0]   req_key,
   input  logic [VALUE_W-1:0] req_write_value,
   input  logic               rsp_strobe,
   input  logic               rsp_found,
   input  logic [VALUE_W-1:0] rsp_read_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output int                 errors,
   output int                 pending,
   output int                 replies_seen,
   output int                 hits
);

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
   } reply_type;

   // shadow copy of the cache
   logic               slot_valid [ENTRIES];
   logic [KEY_W-1:0]   slot_key   [ENTRIES];
   logic [VALUE_W-1:0] slot_value [ENTRIES];
   logic [RANK_W-1:0]  slot_rank  [ENTRIES];
   logic [CAP_W-1:0]   fill_level;
   logic [CAP_W-1:0]   cap_setting;

   reply_type pending_replies [$];
   int        error_count;

   assign errors  = error_count;
   assign pending = pending_replies.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s on reply %0d: got %h, expected %h",
               what, replies_seen, got, want);
      error_count++;
   endtask

   // apply one lookup or write to the shadow copy and return its reply
   function automatic reply_type predict_access(input kind_type kind,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VALUE_W-1:0] wval);
      reply_type         r;
      int                hit;
      int                victim;
      logic [RANK_W-1:0] old_rank;
      hit = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;
      end
      r.found      = (hit >= 0);
      r.read_value = '0;
      if (hit >= 0) begin
         if (kind == KIND_GET) r.read_value = slot_value[hit];
         else slot_value[hit] = wval;
         // promote to most recent, entries that were more recent age by one
         old_rank = slot_rank[hit];
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && i != hit && slot_rank[i] < old_rank)
               slot_rank[i] = slot_rank[i] + 1'b1;
         end
         slot_rank[hit] = '0;
      end else if (kind == KIND_PUT) begin
         // full at the current capacity: drop the least recent entry only
         if (fill_level >= cap_setting) begin
            victim = -1;
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                  victim = i;
            end
            if (victim >= 0) begin
               slot_valid[victim] = 1'b0;
               fill_level = fill_level - 1'b1;
            end
         end
         // insert into the first free slot as most recent
         for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
               for (int j = 0; j < ENTRIES; j++) begin
                  if (slot_valid[j]) slot_rank[j] = slot_rank[j] + 1'b1;
               end
               slot_valid[i] = 1'b1;
               slot_key[i]   = key;
               slot_value[i] = wval;
               slot_rank[i]  = '0;
               fill_level    = fill_level + 1'b1;
               break;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type want;
      logic [CAP_W-1:0] cap_raw;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = '0;
         end
         fill_level   = '0;
         cap_setting  = (CAP_RESET_VALUE > ENTRIES) ? CAP_W'(ENTRIES)
                                                    : CAP_W'(CAP_RESET_VALUE);
         pending_replies.delete();
         error_count  = 0;
         replies_seen = 0;
         hits         = 0;
      end else begin
         // reply word first: it belongs to an earlier request
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               report_mismatch("reply with nothing outstanding", rsp_read_value, '0);
            end else begin
               want = pending_replies.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", 32'(rsp_found), 32'(want.found));
               if (rsp_read_value !== want.read_value)
                  report_mismatch("read_value", rsp_read_value, want.read_value);
               if (want.found) hits++;
            end
            replies_seen++;
         end
         // accepted request word
         if (start && !busy) begin
            pending_replies.push_back(predict_access(kind_type'(req_kind), req_key,
                                                     req_write_value));
         end
         // capacity register write, zero taken as one, saturating at the cell count
         if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            cap_raw = pwdata[CAP_W-1:0];
            if (cap_raw == 0) cap_raw = CAP_W'(1);
            if (cap_raw > ENTRIES) cap_raw = CAP_W'(ENTRIES);
            cap_setting = cap_raw;
         end
      end
   end

endmodule

FILE: tb/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Drives lookups and writes into the LRU key/value cache over a series of
// capacity settings: a directed opening on the corner cases, then random
// traffic over small key pools so that hits, updates and evictions are
// frequent. The checker beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
   import lkvc_pkg::*;

   localparam int ENTRIES     = ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 146;
   localparam int POOL_MAX    = 12;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_kind;
   logic [KEY_W-1:0]   req_key;
   logic [VALUE_W-1:0] req_write_value;
   logic               rsp_strobe;
   logic               rsp_found;
   logic [VALUE_W-1:0] rsp_read_value;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   int errors;
   int pending;
   int replies_seen;
   int hits;
   int cycle_count = 0;
   int setting_count = 0;
   bit idle_enable = 1'b1;

   logic [CAP_W-1:0]   cap_list [12] = '{4'd8, 4'd1, 4'd3, 4'd15, 4'd0, 4'd6,
                                         4'd2, 4'd9, 4'd5, 4'd4, 4'd7, 4'd12};
   logic [KEY_W-1:0]   key_pool [POOL_MAX];

   // clock, 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key(req_key), .req_write_value(req_write_value),
      .rsp_strobe(rsp_strobe), .rsp_found(rsp_found), .rsp_read_value(rsp_read_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   lkvc_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_key(req_key), .req_write_value(req_write_value),
      .rsp_strobe(rsp_strobe), .rsp_found(rsp_found), .rsp_read_value(rsp_read_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending),
      .replies_seen(replies_seen), .hits(hits)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // present one request word and hold it until it is taken
   task automatic send_word(input kind_type kind, input logic [KEY_W-1:0] key,
                            input logic [VALUE_W-1:0] wval);
      while (idle_enable && $urandom_range(99) < 23) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start           <= 1'b1;
      req_kind        <= kind;
      req_key         <= key;
      req_write_value <= wval;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // drain outstanding replies, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // capacity write, setup then access cycle, random upper data bits
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      logic [DATA_W-1:0] noise;
      noise = $urandom;
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= '0;
      pwdata  <= {noise[DATA_W-1:CAP_W], cap};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      setting_count++;
   endtask

   initial begin
      int pool_size;
      logic [KEY_W-1:0] key;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_kind        <= KIND_GET;
      req_key         <= '0;
      req_write_value <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: miss on empty cache, extreme keys and values, update in place
      send_word(KIND_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(KIND_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(KIND_PUT, 32'h0000_0000, 32'h5A5A_5A5A);
      send_word(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      // fill every cell, refresh one, then force an eviction
      for (int i = 1; i <= 6; i++) send_word(KIND_PUT, KEY_W'(i), $urandom);
      send_word(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(KIND_PUT, 32'd7, $urandom);
      send_word(KIND_GET, 32'h0000_0000, 32'h0000_0000);
      // capacity lowered below occupancy: one eviction per new key
      write_capacity(4'd2);
      send_word(KIND_PUT, 32'd8, $urandom);
      send_word(KIND_GET, 32'd1, 32'h0000_0000);
      send_word(KIND_PUT, 32'd9, $urandom);
      send_word(KIND_GET, 32'd7, 32'h0000_0000);
      // zero capacity behaves as one
      write_capacity(4'd0);
      send_word(KIND_PUT, 32'hA5A5_0001, 32'h1234_5678);
      send_word(KIND_GET, 32'hA5A5_0001, 32'h0000_0000);
      send_word(KIND_PUT, 32'h5A5A_0002, 32'h8765_4321);
      send_word(KIND_GET, 32'hA5A5_0001, 32'h0000_0000);

      // random phases, each with its own capacity and key pool
      foreach (cap_list[p]) begin
         write_capacity(cap_list[p]);
         idle_enable = (p != 3);
         pool_size = $urandom_range(POOL_MAX, 2);
         for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(pool_size - 1)];
            else key = $urandom;
            send_word(kind_type'($urandom_range(1)), key, $urandom);
         end
      end
      idle_enable = 1'b1;

      wait_idle();
      repeat (4) @(posedge clock);
      $display("covered %0d replies (%0d hits) over %0d capacity settings",
               replies_seen, hits, setting_count + 1);
      $display("including saturated, zero and lowered-below-occupancy capacities");
      if (errors == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lkvc_csr.sv
rtl/lru_key_value_cache.sv
tb/lkvc_checker.sv
tb/tb_lru_key_value_cache.sv
